>>> sv/lvf_pkg.sv
// ----------------------------------------------------------------------------
// lvf_pkg: shared types, constants and curve tables
// Widths, filter constants, discharge curve and sequencer types for the
// battery voltage filter and state-of-charge estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package lvf_pkg;

	// Samples averaged per reading; must be a power of two.
	localparam int unsigned SAMPLES   = 16;
	localparam int unsigned SUM_SHIFT = $clog2(SAMPLES);

	localparam int CNT_W     = 6;
	localparam int SUM_W     = 18;
	localparam int PIN_W     = 12;
	localparam int RATIO_W   = 12;
	localparam int MV_W      = 14;
	localparam int FILT_W    = 22;
	localparam int PCT_W     = 7;
	localparam int MAC_A_W   = 22;
	localparam int MAC_B_W   = 12;
	localparam int MAC_W     = 34;
	localparam int REM_W     = 20;
	localparam int DIFF_W    = 16;
	localparam int DPCT_W    = 4;
	localparam int DMV_W     = 8;
	localparam int STEP_W    = 2;
	localparam int SEG_W     = 4;
	localparam int SEG_COUNT = 10;
	localparam int CURVE_W   = 13;

	localparam logic [CNT_W-1:0]   GROUP_COUNT   = CNT_W'(SAMPLES);
	localparam logic [FILT_W-1:0]  MV_MAX_Q8     = FILT_W'(16383 * 256);
	localparam logic [FILT_W-1:0]  LOAD_LIMIT_Q8 = FILT_W'(1000 * 256);
	localparam logic [FILT_W-1:0]  SOC_HI_Q8     = FILT_W'(4200 * 256);
	localparam logic [FILT_W-1:0]  SOC_LO_Q8     = FILT_W'(3300 * 256);
	localparam logic [MAC_B_W-1:0] EMA_NEW       = MAC_B_W'(205);
	localparam logic [MAC_B_W-1:0] EMA_OLD       = MAC_B_W'(1024 - 205);
	localparam logic [MAC_W-1:0]   EMA_ROUND     = MAC_W'(512);
	localparam logic [PCT_W-1:0]   PCT_FULL      = PCT_W'(100);
	localparam logic [STEP_W-1:0]  DIV_FIRST     = STEP_W'(3);

	// Configuration register indexes
	localparam logic REG_DIVIDER = 1'b0;
	localparam logic REG_MIN_MV  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAW,
		ST_CHK,
		ST_EMA1,
		ST_EMA2,
		ST_EMAW,
		ST_SEG,
		ST_DIVLD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MAC_RAW,
		MAC_EMA_OLD,
		MAC_EMA_NEW,
		MAC_SEG
	} mac_op_t;

	typedef struct packed {
		mac_op_t mac_op;
		logic    mac_en;
		logic    in_ready;
		logic    chk;
		logic    emaw;
		logic    seg;
		logic    divld;
		logic    div;
		logic    done_load;
	} ctrl_t;

	typedef struct packed {
		logic last_xfer;
		logic absent;
		logic load;
		logic clamp;
		logic div_last;
		logic out_free;
	} stat_t;

	// Discharge curve breakpoints, highest voltage first.
	function automatic logic [CURVE_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
		logic [CURVE_W-1:0] mv;
		case (idx)
			4'd0:    mv = CURVE_W'(4200);
			4'd1:    mv = CURVE_W'(4100);
			4'd2:    mv = CURVE_W'(4000);
			4'd3:    mv = CURVE_W'(3900);
			4'd4:    mv = CURVE_W'(3820);
			4'd5:    mv = CURVE_W'(3750);
			4'd6:    mv = CURVE_W'(3700);
			4'd7:    mv = CURVE_W'(3650);
			4'd8:    mv = CURVE_W'(3550);
			4'd9:    mv = CURVE_W'(3400);
			4'd10:   mv = CURVE_W'(3300);
			default: mv = CURVE_W'(3300);
		endcase
		return mv;
	endfunction

	function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
		logic [PCT_W-1:0] pct;
		case (idx)
			4'd0:    pct = PCT_W'(100);
			4'd1:    pct = PCT_W'(90);
			4'd2:    pct = PCT_W'(80);
			4'd3:    pct = PCT_W'(70);
			4'd4:    pct = PCT_W'(55);
			4'd5:    pct = PCT_W'(40);
			4'd6:    pct = PCT_W'(30);
			4'd7:    pct = PCT_W'(20);
			4'd8:    pct = PCT_W'(10);
			4'd9:    pct = PCT_W'(3);
			4'd10:   pct = PCT_W'(0);
			default: pct = PCT_W'(0);
		endcase
		return pct;
	endfunction

endpackage

`default_nettype wire

>>> sv/lvf_mac.sv
// ----------------------------------------------------------------------------
// lvf_mac: shared multiply-add unit
// Computes a * b + c and registers the result; reused for scaling, filter
// and curve interpolation steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lvf_mac (
	input  wire                          clk,
	input  wire                          en,
	input  wire [lvf_pkg::MAC_A_W-1:0]   a,
	input  wire [lvf_pkg::MAC_B_W-1:0]   b,
	input  wire [lvf_pkg::MAC_W-1:0]     c,
	output logic [lvf_pkg::MAC_W-1:0]    p
);

	logic [lvf_pkg::MAC_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= lvf_pkg::MAC_W'(a) * lvf_pkg::MAC_W'(b) + c;
		end
	end

	assign p = p_q;

endmodule

`default_nettype wire

>>> sv/lvf_seq.sv
// ----------------------------------------------------------------------------
// lvf_seq: reading sequencer
// Steps one reading through scaling, connect test, filter update, curve
// lookup, quotient steps and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lvf_seq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lvf_pkg::stat_t       stat,
	output lvf_pkg::ctrl_t       ctrl
);

	lvf_pkg::state_t state_q;
	lvf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lvf_pkg::ST_IDLE: begin
				if (stat.last_xfer) state_d = lvf_pkg::ST_RAW;
			end
			lvf_pkg::ST_RAW:  state_d = lvf_pkg::ST_CHK;
			lvf_pkg::ST_CHK: begin
				if (stat.absent)    state_d = lvf_pkg::ST_DONE;
				else if (stat.load) state_d = lvf_pkg::ST_SEG;
				else                state_d = lvf_pkg::ST_EMA1;
			end
			lvf_pkg::ST_EMA1: state_d = lvf_pkg::ST_EMA2;
			lvf_pkg::ST_EMA2: state_d = lvf_pkg::ST_EMAW;
			lvf_pkg::ST_EMAW: state_d = lvf_pkg::ST_SEG;
			lvf_pkg::ST_SEG: begin
				if (stat.clamp) state_d = lvf_pkg::ST_DONE;
				else            state_d = lvf_pkg::ST_DIVLD;
			end
			lvf_pkg::ST_DIVLD: state_d = lvf_pkg::ST_DIV;
			lvf_pkg::ST_DIV: begin
				if (stat.div_last) state_d = lvf_pkg::ST_DONE;
			end
			lvf_pkg::ST_DONE: begin
				if (stat.out_free) state_d = lvf_pkg::ST_IDLE;
			end
			default: state_d = lvf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.mac_op    = lvf_pkg::MAC_RAW;
		case (state_q)
			lvf_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
			lvf_pkg::ST_RAW: begin
				ctrl.mac_en = 1'b1;
				ctrl.mac_op = lvf_pkg::MAC_RAW;
			end
			lvf_pkg::ST_CHK: ctrl.chk = 1'b1;
			lvf_pkg::ST_EMA1: begin
				ctrl.mac_en = 1'b1;
				ctrl.mac_op = lvf_pkg::MAC_EMA_OLD;
			end
			lvf_pkg::ST_EMA2: begin
				ctrl.mac_en = 1'b1;
				ctrl.mac_op = lvf_pkg::MAC_EMA_NEW;
			end
			lvf_pkg::ST_EMAW: ctrl.emaw = 1'b1;
			lvf_pkg::ST_SEG: begin
				ctrl.seg    = 1'b1;
				ctrl.mac_en = 1'b1;
				ctrl.mac_op = lvf_pkg::MAC_SEG;
			end
			lvf_pkg::ST_DIVLD: ctrl.divld = 1'b1;
			lvf_pkg::ST_DIV:   ctrl.div = 1'b1;
			lvf_pkg::ST_DONE:  ctrl.done_load = stat.out_free;
			default: ctrl.in_ready = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/lipo_voltage_filter_soc_unit.sv
// ----------------------------------------------------------------------------
// lipo_voltage_filter_soc_unit: battery voltage filter and charge estimate
// Averages pin samples in groups, scales by the divider ratio, tests for a
// connected battery, smooths with an EMA and maps to state of charge.
// ----------------------------------------------------------------------------
// A sample that does not close a group is only added to the group sum. The
// sample that closes a group starts a reading that one shared multiply-add
// unit and a small sequencer carry through: with no battery present it goes
// from scaling and the connect test to the result; when the filter updates and
// the charge falls inside a curve segment it takes scale, filter multiply-adds,
// interpolation multiply and a 4-step quotient; the result may then wait for
// the output side. No sample is taken while a reading is in progress. Output
// tdata holds the result until transferred; the filter and group sum reset to zero.
`default_nettype none

module lipo_voltage_filter_soc_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [11:0] pin_mv
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // [13:0] battery_mv, [20:14] charge_percent,
	                               // [21] battery_present
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [13:0] cfg_data
);

	lvf_pkg::ctrl_t ctrl;
	lvf_pkg::stat_t stat;

	logic [lvf_pkg::RATIO_W-1:0] ratio_q;
	logic [lvf_pkg::MV_W-1:0]    min_mv_q;
	logic [lvf_pkg::SUM_W-1:0]   sum_q;
	logic [lvf_pkg::CNT_W-1:0]   count_q;
	logic [lvf_pkg::SUM_W-1:0]   grp_sum_q;
	logic [lvf_pkg::FILT_W-1:0]  filt_q;
	logic [lvf_pkg::FILT_W-1:0]  raw_q;
	logic                        present_q;
	logic [lvf_pkg::PCT_W-1:0]   soc_q;
	logic [lvf_pkg::DMV_W-1:0]   dmv_q;
	logic [lvf_pkg::REM_W-1:0]   rem_q;
	logic [lvf_pkg::STEP_W-1:0]  step_q;
	logic                        m_tvalid_q;
	logic [lvf_pkg::MV_W-1:0]    out_mv_q;
	logic [lvf_pkg::PCT_W-1:0]   out_pct_q;
	logic                        out_present_q;

	logic                        xfer;
	logic [lvf_pkg::SUM_W-1:0]   sum_next;
	logic [lvf_pkg::CNT_W-1:0]   count_next;

	logic [lvf_pkg::MAC_A_W-1:0] mac_a;
	logic [lvf_pkg::MAC_B_W-1:0] mac_b;
	logic [lvf_pkg::MAC_W-1:0]   mac_c;
	logic [lvf_pkg::MAC_W-1:0]   mac_p;

	logic [lvf_pkg::MAC_W-1:0]   raw_full;
	logic [lvf_pkg::FILT_W-1:0]  raw_sat;

	logic                        clamp_hi;
	logic                        clamp_lo;
	logic [lvf_pkg::SEG_W-1:0]   seg;
	logic [lvf_pkg::SEG_W-1:0]   seg_lo;
	logic [lvf_pkg::FILT_W-1:0]  lo_q8;
	logic [lvf_pkg::DIFF_W-1:0]  diff;
	logic [lvf_pkg::DPCT_W-1:0]  dpct;
	logic [lvf_pkg::DMV_W-1:0]   dmv;

	logic [lvf_pkg::REM_W-1:0]   div_sub;
	logic [lvf_pkg::FILT_W:0]    mv_round;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= lvf_pkg::RATIO_W'(512);
			min_mv_q <= lvf_pkg::MV_W'(2000);
		end else if (cfg_we) begin
			case (cfg_index)
				lvf_pkg::REG_DIVIDER: ratio_q  <= cfg_data[lvf_pkg::RATIO_W-1:0];
				lvf_pkg::REG_MIN_MV:  min_mv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample accumulation
	assign xfer       = s_tvalid && s_tready;
	assign sum_next   = sum_q + lvf_pkg::SUM_W'(s_tdata[lvf_pkg::PIN_W-1:0]);
	assign count_next = count_q + lvf_pkg::CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (xfer) begin
			if (count_next == lvf_pkg::GROUP_COUNT) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.last_xfer) begin
			grp_sum_q <= sum_next;
		end
	end

	// Raw voltage from the scaled group sum
	assign raw_full = mac_p >> lvf_pkg::SUM_SHIFT;
	assign raw_sat  = (raw_full > lvf_pkg::MAC_W'(lvf_pkg::MV_MAX_Q8)) ?
	                  lvf_pkg::MV_MAX_Q8 : raw_full[lvf_pkg::FILT_W-1:0];

	// Curve segment search on the filter value
	assign clamp_hi = filt_q >= lvf_pkg::SOC_HI_Q8;
	assign clamp_lo = filt_q <= lvf_pkg::SOC_LO_Q8;

	always_comb begin
		seg = '0;
		for (int i = lvf_pkg::SEG_COUNT - 1; i >= 0; i--) begin
			if (filt_q >= {lvf_pkg::FILT_W'(lvf_pkg::curve_mv(lvf_pkg::SEG_W'(i + 1))) << 8}) begin
				seg = lvf_pkg::SEG_W'(i);
			end
		end
	end

	assign seg_lo = seg + lvf_pkg::SEG_W'(1);
	assign lo_q8  = lvf_pkg::FILT_W'(lvf_pkg::curve_mv(seg_lo)) << 8;
	assign diff   = lvf_pkg::DIFF_W'(filt_q - lo_q8);
	assign dpct   = lvf_pkg::DPCT_W'(lvf_pkg::curve_pct(seg) - lvf_pkg::curve_pct(seg_lo));
	assign dmv    = lvf_pkg::DMV_W'(lvf_pkg::curve_mv(seg) - lvf_pkg::curve_mv(seg_lo));

	// Shared multiply-add operand select
	always_comb begin
		case (ctrl.mac_op)
			lvf_pkg::MAC_RAW: begin
				mac_a = lvf_pkg::MAC_A_W'(grp_sum_q);
				mac_b = ratio_q;
				mac_c = '0;
			end
			lvf_pkg::MAC_EMA_OLD: begin
				mac_a = filt_q;
				mac_b = lvf_pkg::EMA_OLD;
				mac_c = '0;
			end
			lvf_pkg::MAC_EMA_NEW: begin
				mac_a = raw_q;
				mac_b = lvf_pkg::EMA_NEW;
				mac_c = mac_p + lvf_pkg::EMA_ROUND;
			end
			lvf_pkg::MAC_SEG: begin
				mac_a = lvf_pkg::MAC_A_W'(diff);
				mac_b = lvf_pkg::MAC_B_W'(dpct);
				mac_c = lvf_pkg::MAC_W'(dmv) << 7;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
				mac_c = '0;
			end
		endcase
	end

	lvf_mac u_mac (
		.clk (clk),
		.en  (ctrl.mac_en),
		.a   (mac_a),
		.b   (mac_b),
		.c   (mac_c),
		.p   (mac_p)
	);

	// Quotient step: one bit of the rounded interpolation per cycle
	assign div_sub = lvf_pkg::REM_W'({dmv_q, 8'b0}) << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (ctrl.chk) begin
			if (stat.absent)    filt_q <= '0;
			else if (stat.load) filt_q <= raw_sat;
		end else if (ctrl.emaw) begin
			filt_q <= mac_p[lvf_pkg::FILT_W+9:10];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.chk) begin
			raw_q     <= raw_sat;
			present_q <= !stat.absent;
			soc_q     <= '0;
		end
		if (ctrl.seg) begin
			dmv_q <= dmv;
			if (clamp_hi)      soc_q <= lvf_pkg::PCT_FULL;
			else if (clamp_lo) soc_q <= '0;
			else               soc_q <= lvf_pkg::curve_pct(seg_lo);
		end
		if (ctrl.divld) begin
			rem_q  <= mac_p[lvf_pkg::REM_W-1:0];
			step_q <= lvf_pkg::DIV_FIRST;
		end
		if (ctrl.div) begin
			if (rem_q >= div_sub) begin
				rem_q <= rem_q - div_sub;
				soc_q <= soc_q + (lvf_pkg::PCT_W'(1) << step_q);
			end
			step_q <= step_q - lvf_pkg::STEP_W'(1);
		end
	end

	// Status to the sequencer
	always_comb begin
		stat.last_xfer = xfer && (count_next == lvf_pkg::GROUP_COUNT);
		stat.absent    = raw_sat[lvf_pkg::FILT_W-1:8] < min_mv_q;
		stat.load      = filt_q < lvf_pkg::LOAD_LIMIT_Q8;
		stat.clamp     = clamp_hi || clamp_lo;
		stat.div_last  = step_q == '0;
		stat.out_free  = !m_tvalid_q || m_tready;
	end

	lvf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Output register
	assign mv_round = {1'b0, filt_q} + (lvf_pkg::FILT_W + 1)'(128);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.done_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done_load) begin
			out_mv_q      <= mv_round[lvf_pkg::MV_W+7:8];
			out_pct_q     <= soc_q;
			out_present_q <= present_q;
		end
	end

	assign s_tready = ctrl.in_ready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b0, out_present_q, out_pct_q, out_mv_q};

endmodule

`default_nettype wire
